// ----- src/page_frame_free_list_allocator_assert.svh -----
// Assertion macros for the page frame allocator.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pffl_pkg.sv -----
// Shared constants, codes and types of the page frame allocator.
// No dependencies.
package pffl_pkg;

  localparam int NUM_FRAMES_DEF = 256;
  localparam int MAX_ALLOC_DEF  = 16;

  localparam int FRAME_W  = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

  // Port controls of the frame store
  typedef struct packed {
    logic q_we;     // queue write
    logic q_re;     // queue read
    logic u_we;     // used-mark write
    logic u_wdata;  // used-mark write value
    logic u_re;     // used-mark read
  } mem_ctl_t;

endpackage

// ----- src/pffl_req_if.sv -----
// Request channel of the page frame allocator.
// Depends on pffl_pkg.
interface pffl_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [pffl_pkg::COUNT_W-1:0] count;
  logic [pffl_pkg::FRAME_W-1:0] frame;

  modport source (output valid, output req_type, output count, output frame, input ready);
  modport sink   (input valid, input req_type, input count, input frame, output ready);
endinterface

// ----- src/pffl_rsp_if.sv -----
// Result channel of the page frame allocator.
// Depends on pffl_pkg.
interface pffl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pffl_pkg::FRAME_W-1:0]  frame_out;
  logic [pffl_pkg::STATUS_W-1:0] status;
  logic                         last;

  modport source (output valid, output frame_out, output status, output last, input ready);
  modport sink   (input valid, input frame_out, input status, input last, output ready);
endinterface

// ----- src/page_frame_free_list_allocator.sv -----
// Page frame allocator: free frames in a FIFO queue, one used mark per frame.
// After reset a clearing pass loads the queue with frame numbers in ascending
// order and clears all used marks; no request is taken during it. An allocate
// of N frames sends one result per frame, since the sequencer issues the registered
// read of the queue memory for each frame only after the previous frame has been
// sent. A free, or any failed request, gives a single result. Requests are handled
// one at a time; a result waits in an output register while the block goes on.
// Depends on pffl_pkg, pffl_req_if, pffl_rsp_if, pffl_store and the assertion
// header.
module page_frame_free_list_allocator #(
  parameter int NUM_FRAMES = pffl_pkg::NUM_FRAMES_DEF,
  parameter int MAX_ALLOC  = pffl_pkg::MAX_ALLOC_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  pffl_req_if.sink   req_i,
  pffl_rsp_if.source rsp_o
);

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int KW = pffl_pkg::COUNT_W;

  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_FRAMES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(NUM_FRAMES);

  // Sequencer states
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ACHK = 3'd2;
  localparam logic [2:0] S_ARD  = 3'd3;
  localparam logic [2:0] S_AOUT = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_FCHK = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] free_cnt_q, free_cnt_d;
  logic [KW-1:0] k_q, k_d;

  // Latched request
  logic                            type_q;
  logic [KW-1:0]                   cnt_q;
  logic [pffl_pkg::FRAME_W-1:0]    fr_q;
  logic [pffl_pkg::STATUS_W-1:0]   res_st_q, res_st_d;

  // Output register
  logic                            rsp_valid_q, rsp_valid_d;
  logic [pffl_pkg::FRAME_W-1:0]    rsp_frame_q, rsp_frame_d;
  logic [pffl_pkg::STATUS_W-1:0]   rsp_status_q, rsp_status_d;
  logic                            rsp_last_q, rsp_last_d;

  pffl_pkg::mem_ctl_t ctl;
  logic [AW-1:0]      q_waddr, q_wdata, q_rdata, u_waddr;
  logic               u_rdata;

  logic          req_xfer;
  logic          out_free;
  logic          fr_in_range;
  logic          alloc_bad;
  logic          k_last;
  logic [AW-1:0] fr_idx;

  assign req_i.ready   = (state_q == S_IDLE);
  assign req_xfer      = req_i.valid && req_i.ready;
  assign out_free      = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.frame_out = rsp_frame_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.last      = rsp_last_q;

  assign fr_idx      = AW'(fr_q);
  assign fr_in_range = 32'(fr_q) < 32'(NUM_FRAMES);
  assign alloc_bad   = (cnt_q == '0) || (32'(cnt_q) > 32'(MAX_ALLOC))
                       || (32'(cnt_q) > 32'(free_cnt_q));
  assign k_last      = (KW'(k_q + 1'b1) == cnt_q);

  pffl_store #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .q_waddr_i (q_waddr),
    .q_wdata_i (q_wdata),
    .q_raddr_i (head_q),
    .q_rdata_o (q_rdata),
    .u_waddr_i (u_waddr),
    .u_raddr_i (fr_idx),
    .u_rdata_o (u_rdata)
  );

  // Sequencer and store control
  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_cnt_d   = free_cnt_q;
    k_d          = k_q;
    res_st_d     = res_st_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_frame_d  = rsp_frame_q;
    rsp_status_d = rsp_status_q;
    rsp_last_d   = rsp_last_q;
    ctl          = '0;
    q_waddr      = tail_q;
    q_wdata      = fr_idx;
    u_waddr      = fr_idx;

    unique case (state_q)
      S_INIT: begin
        // Clearing pass: queue[i] = i, used[i] = 0
        ctl.q_we  = 1'b1;
        ctl.u_we  = 1'b1;
        q_waddr   = clr_idx_q;
        q_wdata   = clr_idx_q;
        u_waddr   = clr_idx_q;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_xfer) begin
          state_d = (req_i.req_type == pffl_pkg::REQ_FREE) ? S_FRD : S_ACHK;
        end
      end
      S_ACHK: begin
        k_d = '0;
        if (alloc_bad) begin
          res_st_d = pffl_pkg::ST_SHORT;
          state_d  = S_EMIT;
        end else begin
          state_d = S_ARD;
        end
      end
      S_ARD: begin
        ctl.q_re = 1'b1;
        state_d  = S_AOUT;
      end
      S_AOUT: begin
        // Send one frame, mark it used and pop it
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_frame_d  = pffl_pkg::FRAME_W'(q_rdata);
          rsp_status_d = pffl_pkg::ST_OK;
          rsp_last_d   = k_last;
          ctl.u_we     = 1'b1;
          ctl.u_wdata  = 1'b1;
          u_waddr      = q_rdata;
          head_d       = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
          free_cnt_d   = free_cnt_q - 1'b1;
          k_d          = k_q + 1'b1;
          state_d      = k_last ? S_IDLE : S_ARD;
        end
      end
      S_FRD: begin
        ctl.u_re = 1'b1;
        state_d  = S_FCHK;
      end
      S_FCHK: begin
        if (fr_in_range && u_rdata) begin
          ctl.u_we   = 1'b1;
          ctl.q_we   = 1'b1;
          tail_d     = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
          free_cnt_d = free_cnt_q + 1'b1;
          res_st_d   = pffl_pkg::ST_OK;
        end else begin
          res_st_d = pffl_pkg::ST_NOT_USED;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // Single result: free acknowledge or failure
        if (out_free) begin
          rsp_valid_d  = 1'b1;
          rsp_frame_d  = '0;
          rsp_status_d = res_st_q;
          rsp_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_idx_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      free_cnt_q  <= FULL_CNT;
      k_q         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_cnt_q  <= free_cnt_d;
      k_q         <= k_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      type_q <= req_i.req_type;
      cnt_q  <= req_i.count;
      fr_q   <= req_i.frame;
    end
    res_st_q     <= res_st_d;
    rsp_frame_q  <= rsp_frame_d;
    rsp_status_q <= rsp_status_d;
    rsp_last_q   <= rsp_last_d;
  end

`include "page_frame_free_list_allocator_assert.svh"

  `PFFL_ASSERT_IMP(a_cnt_bound, 1'b1, free_cnt_q <= FULL_CNT, "free count above frame count")
  `PFFL_ASSERT_IMP(a_ptr_match, (free_cnt_q == FULL_CNT) || (free_cnt_q == '0), head_q == tail_q, "queue pointers disagree with free count")
  `PFFL_ASSERT_IMP(a_fail_last, rsp_valid_q && (rsp_status_q != pffl_pkg::ST_OK), rsp_last_q && (rsp_frame_q == '0), "failure result not single")
  `PFFL_ASSERT_IMP(a_init_quiet, state_q == S_INIT, !rsp_valid_q, "result during clearing pass")
  `PFFL_ASSERT_NXT(a_alloc_type, (state_q == S_ACHK) || (state_q == S_ARD), type_q == pffl_pkg::REQ_ALLOC, "allocate path entered by free")

endmodule

// ----- src/pffl_store.sv -----
// Frame store: free queue memory and per-frame used marks.
// One write and one registered read per memory each cycle. Depends on pffl_pkg.
module pffl_store #(
  parameter int NUM_FRAMES = pffl_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  pffl_pkg::mem_ctl_t            ctl_i,
  input  logic [$clog2(NUM_FRAMES)-1:0] q_waddr_i,
  input  logic [$clog2(NUM_FRAMES)-1:0] q_wdata_i,
  input  logic [$clog2(NUM_FRAMES)-1:0] q_raddr_i,
  output logic [$clog2(NUM_FRAMES)-1:0] q_rdata_o,
  input  logic [$clog2(NUM_FRAMES)-1:0] u_waddr_i,
  input  logic [$clog2(NUM_FRAMES)-1:0] u_raddr_i,
  output logic                          u_rdata_o
);

  localparam int AW = $clog2(NUM_FRAMES);

  logic [AW-1:0] queue_mem [NUM_FRAMES];
  logic          used_mem  [NUM_FRAMES];

  // Free queue
  always_ff @(posedge clk_i) begin
    if (ctl_i.q_we) begin
      queue_mem[q_waddr_i] <= q_wdata_i;
    end
    if (ctl_i.q_re) begin
      q_rdata_o <= queue_mem[q_raddr_i];
    end
  end

  // Used marks
  always_ff @(posedge clk_i) begin
    if (ctl_i.u_we) begin
      used_mem[u_waddr_i] <= ctl_i.u_wdata;
    end
    if (ctl_i.u_re) begin
      u_rdata_o <= used_mem[u_raddr_i];
    end
  end

endmodule
